FILE: design/assert_macros.svh
// Assertion macros shared by the RTL; they compile to nothing in synthesis.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Clocked implication checked on i_clk, muted while i_rst_n is low.
`define SLE_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Condition that must never be true at a clock edge out of reset.
`define SLE_NEVER(lbl, cond, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) !(cond)) else $error(msg);

`else

`define SLE_ASSERT(lbl, prop, msg)
`define SLE_NEVER(lbl, cond, msg)

`endif

`endif

FILE: design/sle_pkg.sv
// Types, codes and sizes shared by the sorted list engine.
`timescale 1ns / 1ps
`default_nettype none

package sle_pkg;

    localparam int DEPTH     = 64;
    localparam int KEY_WIDTH = 16;
    localparam int ADDR_W    = $clog2(DEPTH);
    localparam int CNT_W     = $clog2(DEPTH + 1);
    localparam int OUT_NUM_W = 7;   // width of position and entry_count on the port

    // request kinds
    localparam logic [1:0] REQ_INSERT = 2'd0;
    localparam logic [1:0] REQ_REMOVE = 2'd1;
    localparam logic [1:0] REQ_SEARCH = 2'd2;
    localparam logic [1:0] REQ_CLEAR  = 2'd3;

    // result status
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [1:0] ST_EMPTY     = 2'd2;
    localparam logic [1:0] ST_FULL      = 2'd3;

    typedef logic [KEY_WIDTH-1:0] t_key;
    typedef logic [ADDR_W-1:0]    t_addr;
    typedef logic [CNT_W-1:0]     t_cnt;

    typedef struct packed {
        logic [1:0] op;
        t_key       key;
    } t_req;

    typedef struct packed {
        logic [OUT_NUM_W-1:0] entry_count;
        logic [OUT_NUM_W-1:0] position;
        logic [1:0]           status;
    } t_result;

    typedef struct packed {
        logic  rd_en;
        t_addr rd_addr;
        logic  wr_en;
        t_addr wr_addr;
        t_key  wr_data;
    } t_ram_req;

    typedef struct packed {
        logic busy;
        t_cnt count;
    } t_ctrl_stat;

endpackage

`default_nettype wire

FILE: design/sle_ram.sv
// Simple dual-port RAM: one write port, one registered read port.
`timescale 1ns / 1ps
`default_nettype none

module sle_ram #(
    parameter int ADDR_BITS = 6,
    parameter int DATA_BITS = 16,
    parameter int WORDS     = 64
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_wr_en,
    input  wire logic [ADDR_BITS-1:0] i_wr_addr,
    input  wire logic [DATA_BITS-1:0] i_wr_data,
    input  wire logic                 i_rd_en,
    input  wire logic [ADDR_BITS-1:0] i_rd_addr,
    output logic      [DATA_BITS-1:0] o_rd_data
);

    logic [DATA_BITS-1:0] r_mem [WORDS];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule

`default_nettype wire

FILE: design/sle_ctrl.sv
// Scan sequencer: walks the key store at most once per request, shifting in place.
`timescale 1ns / 1ps
`default_nettype none

module sle_ctrl import sle_pkg::*; (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_req_valid,
    input  wire t_req       i_req,
    output logic            o_req_ready,
    output logic            o_res_valid,
    input  wire logic       i_res_ready,
    output t_result         o_res,
    output t_ram_req        o_ram,
    input  wire t_key       i_rd_data,
    output t_ctrl_stat      o_stat
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_DONE = 2'd2;

    logic [1:0] r_state,    n_state;
    logic [1:0] r_op,       n_op;
    t_key       r_key,      n_key;
    t_cnt       r_cnt,      n_cnt;
    t_cnt       r_rd_addr,  n_rd_addr;
    logic       r_rd_vld,   n_rd_vld;
    t_addr      r_dat_addr, n_dat_addr;
    logic       r_hit,      n_hit;
    t_key       r_carry,    n_carry;
    logic [1:0] r_status,   n_status;
    t_cnt       r_pos,      n_pos;

    logic issue;

    always_comb begin
        n_state    = r_state;
        n_op       = r_op;
        n_key      = r_key;
        n_cnt      = r_cnt;
        n_rd_addr  = r_rd_addr;
        n_rd_vld   = 1'b0;
        n_dat_addr = r_dat_addr;
        n_hit      = r_hit;
        n_carry    = r_carry;
        n_status   = r_status;
        n_pos      = r_pos;
        o_ram      = '0;
        issue      = (r_state == S_SCAN) && (r_rd_addr < r_cnt);

        case (r_state)
            S_IDLE: begin
                if (i_req_valid) begin
                    n_op      = i_req.op;
                    n_key     = i_req.key;
                    n_rd_addr = '0;
                    n_hit     = 1'b0;
                    n_pos     = '0;
                    n_status  = ST_OK;
                    case (i_req.op)
                        REQ_CLEAR: begin
                            n_cnt   = '0;
                            n_state = S_DONE;
                        end
                        REQ_INSERT: begin
                            if (r_cnt == CNT_W'(DEPTH)) begin
                                n_status = ST_FULL;
                                n_state  = S_DONE;
                            end else begin
                                n_state = S_SCAN;
                            end
                        end
                        default: begin
                            if (r_cnt == '0) begin
                                n_status = ST_EMPTY;
                                n_state  = S_DONE;
                            end else begin
                                n_state = S_SCAN;
                            end
                        end
                    endcase
                end
            end

            S_SCAN: begin
                // read side runs one entry ahead of the compare/write side
                if (issue) begin
                    o_ram.rd_en   = 1'b1;
                    o_ram.rd_addr = r_rd_addr[ADDR_W-1:0];
                    n_rd_addr     = r_rd_addr + 1'b1;
                    n_dat_addr    = r_rd_addr[ADDR_W-1:0];
                    n_rd_vld      = 1'b1;
                end

                if (r_rd_vld) begin
                    case (r_op)
                        REQ_SEARCH: begin
                            if (i_rd_data == r_key) begin
                                n_pos   = CNT_W'(r_dat_addr) + 1'b1;
                                n_state = S_DONE;
                            end
                        end
                        REQ_REMOVE: begin
                            // after the hit, every later key moves down one slot
                            if (r_hit) begin
                                o_ram.wr_en   = 1'b1;
                                o_ram.wr_addr = r_dat_addr - 1'b1;
                                o_ram.wr_data = i_rd_data;
                            end else if (i_rd_data == r_key) begin
                                n_hit = 1'b1;
                            end
                        end
                        REQ_INSERT: begin
                            // once placed, the displaced key rides up one slot a beat
                            if (r_hit) begin
                                o_ram.wr_en   = 1'b1;
                                o_ram.wr_addr = r_dat_addr;
                                o_ram.wr_data = r_carry;
                                n_carry       = i_rd_data;
                            end else if (i_rd_data >= r_key) begin
                                o_ram.wr_en   = 1'b1;
                                o_ram.wr_addr = r_dat_addr;
                                o_ram.wr_data = r_key;
                                n_carry       = i_rd_data;
                                n_hit         = 1'b1;
                            end
                        end
                        default: ;
                    endcase
                end else if (!issue) begin
                    // all entries seen and pipeline drained
                    n_state = S_DONE;
                    case (r_op)
                        REQ_SEARCH: begin
                            n_status = ST_NOT_FOUND;
                        end
                        REQ_REMOVE: begin
                            if (r_hit) begin
                                n_cnt = r_cnt - 1'b1;
                            end else begin
                                n_status = ST_NOT_FOUND;
                            end
                        end
                        REQ_INSERT: begin
                            o_ram.wr_en   = 1'b1;
                            o_ram.wr_addr = r_cnt[ADDR_W-1:0];
                            o_ram.wr_data = r_hit ? r_carry : r_key;
                            n_cnt         = r_cnt + 1'b1;
                        end
                        default: ;
                    endcase
                end
            end

            S_DONE: begin
                if (i_res_ready) begin
                    n_state = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_cnt    <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_cnt    <= n_cnt;
            r_rd_vld <= n_rd_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op       <= n_op;
        r_key      <= n_key;
        r_rd_addr  <= n_rd_addr;
        r_dat_addr <= n_dat_addr;
        r_hit      <= n_hit;
        r_carry    <= n_carry;
        r_status   <= n_status;
        r_pos      <= n_pos;
    end

    assign o_req_ready       = (r_state == S_IDLE);
    assign o_res_valid       = (r_state == S_DONE);
    assign o_res.status      = r_status;
    assign o_res.position    = OUT_NUM_W'(r_pos);
    assign o_res.entry_count = OUT_NUM_W'(r_cnt);
    assign o_stat.busy       = (r_state != S_IDLE);
    assign o_stat.count      = r_cnt;

endmodule

`default_nettype wire

FILE: design/sorted_list_engine.sv
// Top level of the sorted list engine: stream ports, key RAM, scan sequencer.
//
//  channel   dir  sideband       payload
//  s_axis    in   tuser=req_type tdata=key
//  m_axis    out  -              tdata=status, position, entry_count
//
// One request at a time. A request that scans reads all N keys stored
// (1 <= N <= 64) between accept and result: the single read port of the
// key RAM sees one entry per cycle, followed by pipeline drain and finish.
// Clear, full, empty, early search hits and inserts into an empty list finish sooner.
// Reset (i_rst_n low, synchronous) empties the list; RAM contents are left.
// The result sits in an output register, so a stalled sink holds one result
// while the engine already takes and works on the next request.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module sorted_list_engine import sle_pkg::*; (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_tvalid,
    output logic             o_s_tready,
    input  wire logic [15:0] i_s_tdata,   // [15:0] key
    input  wire logic [1:0]  i_s_tuser,   // [1:0] req_type
    output logic             o_m_tvalid,
    input  wire logic        i_m_tready,
    output logic      [15:0] o_m_tdata    // [1:0] status, [8:2] position, [15:9] entry_count
);

    t_req       req;
    logic       res_valid;
    logic       res_ready;
    t_result    res;
    t_ram_req   ram;
    t_key       rd_data;
    t_ctrl_stat stat;

    logic       r_m_valid;
    t_result    r_m_data;

    assign req.op  = i_s_tuser;
    assign req.key = i_s_tdata[KEY_WIDTH-1:0];

    sle_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_s_tvalid),
        .i_req       (req),
        .o_req_ready (o_s_tready),
        .o_res_valid (res_valid),
        .i_res_ready (res_ready),
        .o_res       (res),
        .o_ram       (ram),
        .i_rd_data   (rd_data),
        .o_stat      (stat)
    );

    sle_ram #(
        .ADDR_BITS (ADDR_W),
        .DATA_BITS (KEY_WIDTH),
        .WORDS     (DEPTH)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (ram.wr_en),
        .i_wr_addr (ram.wr_addr),
        .i_wr_data (ram.wr_data),
        .i_rd_en   (ram.rd_en),
        .i_rd_addr (ram.rd_addr),
        .o_rd_data (rd_data)
    );

    // output register: load when empty or when the current beat leaves
    assign res_ready = !r_m_valid || i_m_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (res_ready) begin
            r_m_valid <= res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_ready && res_valid) begin
            r_m_data <= res;
        end
    end

    assign o_m_tvalid = r_m_valid;
    assign o_m_tdata  = r_m_data;

    // one request in flight: ready drops right after an accepted beat
    `SLE_ASSERT(a_one_in_flight, (i_s_tvalid && o_s_tready) |=> !o_s_tready, "second request taken while busy")
    // the RAM is written only while a request is being worked on
    `SLE_NEVER(a_wr_when_idle, ram.wr_en && !stat.busy, "RAM write with engine idle")
    // the stored count stays within the store
    `SLE_NEVER(a_cnt_bound, stat.count > CNT_W'(DEPTH), "entry count beyond depth")
    // a full rejection always reports a full store
    `SLE_ASSERT(a_full_count, (res_valid && res.status == ST_FULL) |-> (stat.count == CNT_W'(DEPTH)), "full status with room left")

endmodule

`default_nettype wire

FILE: sim/sorted_list_checker.sv
// Checker for the sorted list engine: shadow list, result prediction and comparison.
`timescale 1ns / 1ps

module sorted_list_checker import sle_pkg::*; (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_tvalid,
    input  wire logic        i_s_tready,
    input  wire logic [15:0] i_s_tdata,   // [15:0] key
    input  wire logic [1:0]  i_s_tuser,   // [1:0] req_type
    input  wire logic        i_m_tvalid,
    input  wire logic        i_m_tready,
    input  wire logic [15:0] i_m_tdata,   // [1:0] status, [8:2] position, [15:9] entry_count
    output int               o_fail_count,
    output int               o_pending,
    output int               o_checked,
    output int               o_full_rejects
);

    t_key    shadow_keys [DEPTH];
    int      shadow_len;
    t_result awaited_results [$];
    int      fails;
    int      checked;
    int      full_rejects;

    initial begin
        shadow_len   = 0;
        fails        = 0;
        checked      = 0;
        full_rejects = 0;
        o_fail_count   = 0;
        o_pending      = 0;
        o_checked      = 0;
        o_full_rejects = 0;
    end

    // Applies one request to the shadow list and returns the result it should give.
    function automatic t_result apply_request(input logic [1:0] op, input t_key key);
        t_result r;
        int      slot;
        int      j;
        r    = '0;
        slot = 0;
        case (op)
            REQ_INSERT: begin
                if (shadow_len >= DEPTH) begin
                    r.status = ST_FULL;
                    full_rejects++;
                end else begin
                    while (slot < shadow_len && shadow_keys[slot] < key) slot++;
                    for (j = shadow_len; j > slot; j--) shadow_keys[j] = shadow_keys[j-1];
                    shadow_keys[slot] = key;
                    shadow_len++;
                end
            end
            REQ_REMOVE, REQ_SEARCH: begin
                if (shadow_len == 0) begin
                    r.status = ST_EMPTY;
                end else begin
                    while (slot < shadow_len && shadow_keys[slot] != key) slot++;
                    if (slot >= shadow_len) begin
                        r.status = ST_NOT_FOUND;
                    end else if (op == REQ_SEARCH) begin
                        r.position = OUT_NUM_W'(slot + 1);
                    end else begin
                        for (j = slot; j + 1 < shadow_len; j++) shadow_keys[j] = shadow_keys[j+1];
                        shadow_len--;
                    end
                end
            end
            default: begin
                shadow_len = 0;
            end
        endcase
        r.entry_count = OUT_NUM_W'(shadow_len);
        return r;
    endfunction

    task automatic check_field(input string name, input int want, input logic [6:0] got);
        if (got !== want[6:0]) begin
            fails++;
            $error("%s: expected %0d, got %0d", name, want, got);
        end
    endtask

    always @(posedge i_clk) begin
        t_result got;
        t_result want;
        if (!i_rst_n) begin
            shadow_len = 0;
            awaited_results.delete();
        end else begin
            // result side first: a result never belongs to a request taken at the same edge
            if (i_m_tvalid && i_m_tready) begin
                got = t_result'(i_m_tdata);
                if (awaited_results.size() == 0) begin
                    fails++;
                    $error("result beat %h with no request outstanding", i_m_tdata);
                end else begin
                    want = awaited_results.pop_front();
                    checked++;
                    check_field("status", want.status, got.status);
                    check_field("position", want.position, got.position);
                    check_field("entry_count", want.entry_count, got.entry_count);
                end
            end
            if (i_s_tvalid && i_s_tready)
                awaited_results.push_back(apply_request(i_s_tuser, i_s_tdata));
        end
        o_fail_count   <= fails;
        o_pending      <= awaited_results.size();
        o_checked      <= checked;
        o_full_rejects <= full_rejects;
    end

endmodule

FILE: sim/sorted_list_engine_tb.sv
// Testbench top for the sorted list engine: clock, reset, request stimulus and verdict.
`timescale 1ns / 1ps

module sorted_list_engine_tb import sle_pkg::*;;

    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int PHASES       = 10;
    localparam int PHASE_ITEMS  = 200;
    localparam int DRAIN_CYCLES = 80;

    logic        i_clk    = 1'b0;
    logic        i_rst_n  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic [15:0] s_tdata  = '0;
    logic [1:0]  s_tuser  = REQ_INSERT;
    logic        m_tready = 1'b0;
    wire         s_tready;
    wire         m_tvalid;
    wire  [15:0] m_tdata;

    int fail_count;
    int pending;
    int checked;
    int full_rejects;

    bit idling_on   = 1'b1;
    int stall_left  = 0;
    int cycle_count = 0;
    int sent_by_op [4] = '{0, 0, 0, 0};

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    sorted_list_engine uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .i_s_tuser  (s_tuser),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata)
    );

    sorted_list_checker u_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_s_tvalid     (s_tvalid),
        .i_s_tready     (s_tready),
        .i_s_tdata      (s_tdata),
        .i_s_tuser      (s_tuser),
        .i_m_tvalid     (m_tvalid),
        .i_m_tready     (m_tready),
        .i_m_tdata      (m_tdata),
        .o_fail_count   (fail_count),
        .o_pending      (pending),
        .o_checked      (checked),
        .o_full_rejects (full_rejects)
    );

    // Sink side: ready drops at random while idling is on.
    always @(posedge i_clk) begin
        if (stall_left > 0) begin
            m_tready   <= 1'b0;
            stall_left <= stall_left - 1;
        end else if (idling_on && $urandom_range(0, 5) == 0) begin
            m_tready   <= 1'b0;
            stall_left <= $urandom_range(0, 3);
        end else begin
            m_tready <= 1'b1;
        end
    end

    // Watchdog.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding", cycle_count, pending);
            $display("FAIL sorted_list_engine");
            $finish;
        end
    end

    // Presents one request beat and returns at the edge that takes it.
    // Valid stays high across back-to-back beats; a gap lowers it first.
    task automatic send_request(input logic [1:0] op, input logic [15:0] key);
        if (idling_on && $urandom_range(0, 4) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= key;
        @(posedge i_clk);
        while (!s_tready) @(posedge i_clk);
        sent_by_op[op]++;
    endtask

    // Keys: half from a narrow range so hits and duplicates are common,
    // some corner values, the rest over the full 16 bits.
    function automatic logic [15:0] pick_key(input int spread);
        int r;
        r = $urandom_range(0, 9);
        if (r < 5)
            return 16'($urandom_range(0, spread));
        if (r < 7) begin
            case ($urandom_range(0, 3))
                0:       return 16'h0000;
                1:       return 16'hFFFF;
                2:       return 16'h8000;
                default: return 16'h7FFF;
            endcase
        end
        return 16'($urandom);
    endfunction

    function automatic logic [1:0] pick_op(input int w_ins, input int w_rem, input int w_srch);
        int r;
        r = $urandom_range(0, 99);
        if (r < w_ins)                 return REQ_INSERT;
        if (r < w_ins + w_rem)         return REQ_REMOVE;
        if (r < w_ins + w_rem + w_srch) return REQ_SEARCH;
        return REQ_CLEAR;
    endfunction

    initial begin
        int w_ins;
        int w_rem;
        int w_srch;
        int spread;

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: empty-list errors, extremes, duplicates, hits and misses, clear
        send_request(REQ_SEARCH, 16'h0005);
        send_request(REQ_REMOVE, 16'h0005);
        send_request(REQ_INSERT, 16'h0000);
        send_request(REQ_INSERT, 16'hFFFF);
        send_request(REQ_INSERT, 16'h1234);
        send_request(REQ_INSERT, 16'h1234);
        send_request(REQ_SEARCH, 16'h1234);
        send_request(REQ_SEARCH, 16'hFFFF);
        send_request(REQ_SEARCH, 16'h0000);
        send_request(REQ_SEARCH, 16'h0001);
        send_request(REQ_REMOVE, 16'h4321);
        send_request(REQ_REMOVE, 16'h1234);
        send_request(REQ_SEARCH, 16'h1234);
        send_request(REQ_REMOVE, 16'h0000);
        send_request(REQ_REMOVE, 16'hFFFF);
        send_request(REQ_INSERT, 16'h8000);
        send_request(REQ_INSERT, 16'h7FFF);
        send_request(REQ_INSERT, 16'h5555);
        send_request(REQ_INSERT, 16'hAAAA);
        send_request(REQ_CLEAR,  16'hFFFF);
        send_request(REQ_SEARCH, 16'h0000);
        send_request(REQ_INSERT, 16'h0001);
        send_request(REQ_CLEAR,  16'h0000);

        // random phases: fill to full, mixed with duplicates, drain, search-heavy
        for (int phase = 0; phase < PHASES; phase++) begin
            case (phase % 4)
                0:       begin w_ins = 85; w_rem = 5;  w_srch = 9;  spread = 31; end
                1:       begin w_ins = 40; w_rem = 30; w_srch = 29; spread = 7;  end
                2:       begin w_ins = 10; w_rem = 60; w_srch = 29; spread = 31; end
                default: begin w_ins = 30; w_rem = 20; w_srch = 49; spread = 63; end
            endcase
            if (phase == PHASES - 1)
                idling_on = 1'b0;
            repeat (PHASE_ITEMS)
                send_request(pick_op(w_ins, w_rem, w_srch), pick_key(spread));
        end
        s_tvalid <= 1'b0;

        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("requests: %0d insert, %0d remove, %0d search, %0d clear",
                 sent_by_op[REQ_INSERT], sent_by_op[REQ_REMOVE],
                 sent_by_op[REQ_SEARCH], sent_by_op[REQ_CLEAR]);
        $display("results checked: %0d, inserts rejected on a full list: %0d",
                 checked, full_rejects);
        if (fail_count == 0) begin
            $display("PASS sorted_list_engine");
        end else begin
            $display("FAIL sorted_list_engine");
        end
        $finish;
    end

endmodule
